@@ rtl/tpm_pkg.sv @@
package tpm_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_MOVE_TO = 3'd1,
        OP_MOVE_BY = 3'd2,
        OP_STOP    = 3'd3,
        OP_SET_POS = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_SET_RATE = 3'd1,
        CMD_START    = 3'd2,
        CMD_RETARGET = 3'd3,
        CMD_STOP     = 3'd4,
        CMD_SET_POS  = 3'd5
    } cmd_t;

    localparam logic [1:0] REG_CRUISE = 2'd0;
    localparam logic [1:0] REG_ACCEL  = 2'd1;
    localparam logic [1:0] REG_DRIVE  = 2'd2;

    localparam logic [16:0] RAMP_FLOOR   = 17'd400;
    localparam logic [31:0] TICK_US      = 32'd1000;
    localparam logic [19:0] US_PER_S     = 20'd1000000;
    localparam logic [16:0] CRUISE_RESET = 17'd2000;
    localparam logic [19:0] ACCEL_RESET  = 20'd4000;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 60;

endpackage

@@ rtl/trapezoid_ramp_move_planner_unit.sv @@
// Stop, set position, idle or early ticks and ramp starts skip the arithmetic; a move
// while running and a ramp tick go through one shared shift-add multiplier and one
// restoring divider, which produce one bit per cycle each.
// One item at a time: the next beat is taken once the previous item's results
// have been loaded into the emptied output buffer.
// Reset: aresetn is synchronous and active low; it restores the register defaults.
module trapezoid_ramp_move_planner_unit
    import tpm_pkg::*;
#(
    parameter int MAX_STEP_RATE = 100000
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // value[31:0], now_us[63:32], gen_running[64], gen_position[96:65], gen_to_go[128:97]
    input  logic [135:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rate_value[16:0], target_value[48:17], axis_busy[49], planned_end[81:50]
    output logic [87:0]  m_tdata,
    // command[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_TICK_FIN,
        ST_MOVE_FIN,
        ST_EMIT
    } state_t;

    localparam logic [2:0] PC_ACC_EL  = 3'd0;
    localparam logic [2:0] PC_DV      = 3'd1;
    localparam logic [2:0] PC_V_EL    = 3'd2;
    localparam logic [2:0] PC_TRAVEL  = 3'd3;
    localparam logic [2:0] PC_VV      = 3'd4;
    localparam logic [2:0] PC_FF      = 3'd5;
    localparam logic [2:0] PC_STOPD   = 3'd6;

    state_t state_reg;

    logic [2:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [31:0]        now_reg;
    logic               run_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] togo_reg;
    logic signed [31:0] tgt_reg;

    logic [16:0] cruise_reg;
    logic [19:0] accel_reg;
    logic        drive_reg;

    logic               ramp_on_reg;
    logic [25:0]        ramp_rate_reg;
    logic [31:0]        last_time_reg;
    logic               rev_pend_reg;
    logic signed [31:0] rev_tgt_reg;

    logic       move_mode_reg;
    logic [2:0] pc_reg;
    logic [5:0] cnt_reg;

    logic [57:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [57:0] prod_reg;
    logic [36:0] rem_reg;
    logic [59:0] quo_reg;
    logic [36:0] dvsr_reg;

    logic [40:0] dv_reg;
    logic [38:0] trav_reg;
    logic [51:0] vv_reg;
    logic        num_neg_reg;

    logic [2:0]  rcmd0_reg, rcmd1_reg;
    logic [16:0] rrate0_reg, rrate1_reg;
    logic [31:0] rtgt0_reg, rtgt1_reg;
    logic [1:0]  rn_reg;

    logic [2:0]  ocmd0_reg, ocmd1_reg;
    logic [16:0] orate0_reg, orate1_reg;
    logic [31:0] otgt0_reg, otgt1_reg;
    logic        obusy_reg;
    logic [31:0] oend_reg;
    logic [1:0]  ocnt_reg;

    logic [16:0] fl_rate;
    logic [24:0] fl_q8;
    logic [24:0] vt_q8;
    logic [31:0] el;
    logic [25:0] v_sel;
    logic [31:0] abs_togo;
    logic [31:0] base_end;
    logic [31:0] move_tgt;
    logic [57:0] mul_sum;
    logic [37:0] div_r2;
    logic        div_ge;
    logic [37:0] div_diff;
    logic signed [52:0] num_s;
    logic [51:0] num_mag;
    logic [43:0] q;
    logic signed [45:0] sd_s;
    logic signed [45:0] limit_s;
    logic signed [45:0] remain_s;
    logic        decel;
    logic [40:0] v_dn;
    logic [40:0] v_dn_cl;
    logic [41:0] v_up;
    logic [41:0] v_up_cl;
    logic [25:0] v_new;
    logic [30:0] sd_w;
    logic signed [32:0] diff;
    logic signed [33:0] ahead;
    logic        far;
    logic [31:0] steps;
    logic [31:0] steps_cl;
    logic [31:0] stop_pt;
    logic [16:0] cfg_cruise;

    always_comb begin
        fl_rate  = (cruise_reg < RAMP_FLOOR) ? cruise_reg : RAMP_FLOOR;
        fl_q8    = {fl_rate, 8'b0};
        vt_q8    = {cruise_reg, 8'b0};
        el       = now_reg - last_time_reg;
        v_sel    = ramp_on_reg ? ramp_rate_reg : {1'b0, fl_q8};
        abs_togo = togo_reg[31] ? (~togo_reg + 32'd1) : togo_reg;
        base_end = rev_pend_reg ? rev_tgt_reg : (pos_reg + togo_reg);
        move_tgt = (op_reg == OP_MOVE_TO) ? val_reg : (base_end + val_reg);

        mul_sum  = prod_reg + (mplier_reg[0] ? mcand_reg : 58'd0);
        div_r2   = {rem_reg, quo_reg[59]};
        div_ge   = div_r2 >= {1'b0, dvsr_reg};
        div_diff = div_r2 - {1'b0, dvsr_reg};

        num_s   = $signed({1'b0, vv_reg}) - $signed({19'b0, prod_reg[33:0]});
        num_mag = num_s[52] ? 52'(-num_s) : num_s[51:0];
        q       = quo_reg[43:0];

        // Stopping distance is truncated toward zero, so the sign is put back on the magnitude.
        sd_s     = num_neg_reg ? -$signed({2'b0, q}) : $signed({2'b0, q});
        limit_s  = sd_s + $signed({7'b0, trav_reg});
        remain_s = $signed({6'b0, abs_togo, 8'b0});
        decel    = remain_s <= limit_s;

        v_dn    = ({15'b0, ramp_rate_reg} > dv_reg) ? ({15'b0, ramp_rate_reg} - dv_reg) : 41'd0;
        v_dn_cl = (v_dn < {16'b0, fl_q8}) ? {16'b0, fl_q8} : v_dn;
        v_up    = {16'b0, ramp_rate_reg} + {1'b0, dv_reg};
        v_up_cl = (v_up > {17'b0, vt_q8}) ? {17'b0, vt_q8} : v_up;
        priority if (decel) begin
            v_new = v_dn_cl[25:0];
        end else if (ramp_rate_reg < {1'b0, vt_q8}) begin
            v_new = v_up_cl[25:0];
        end else if (ramp_rate_reg > {1'b0, vt_q8}) begin
            v_new = {1'b0, vt_q8};
        end else begin
            v_new = ramp_rate_reg;
        end

        if (num_neg_reg || (q == 44'd0)) begin
            sd_w = 31'd0;
        end else if (q > 44'h0007FFFFFFF) begin
            sd_w = 31'h7FFFFFFF;
        end else begin
            sd_w = q[30:0];
        end
        diff     = $signed({tgt_reg[31], tgt_reg}) - $signed({pos_reg[31], pos_reg});
        ahead    = togo_reg[31] ? -$signed({diff[32], diff}) : $signed({diff[32], diff});
        far      = ahead > $signed({3'b0, sd_w});
        steps    = {1'b0, sd_w} + 32'd1;
        steps_cl = (steps > abs_togo) ? abs_togo : steps;
        stop_pt  = togo_reg[31] ? (pos_reg - steps_cl) : (pos_reg + steps_cl);

        if (cfg_wdata[16:0] == 17'd0) begin
            cfg_cruise = 17'd1;
        end else if (int'(cfg_wdata[16:0]) > MAX_STEP_RATE) begin
            cfg_cruise = 17'(MAX_STEP_RATE);
        end else begin
            cfg_cruise = cfg_wdata[16:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (ocnt_reg != 2'd0);
    assign m_tuser  = ocmd0_reg;
    assign m_tlast  = (ocnt_reg == 2'd1);
    assign m_tdata  = {6'b0, oend_reg, obusy_reg, otgt0_reg, orate0_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cruise_reg    <= CRUISE_RESET;
            accel_reg     <= ACCEL_RESET;
            drive_reg     <= 1'b1;
            ramp_on_reg   <= 1'b0;
            ramp_rate_reg <= '0;
            last_time_reg <= '0;
            rev_pend_reg  <= 1'b0;
            rev_tgt_reg   <= '0;
            ocnt_reg      <= 2'd0;
            rn_reg        <= 2'd0;
        end else begin
            if (m_tvalid && m_tready) begin
                ocmd0_reg  <= ocmd1_reg;
                orate0_reg <= orate1_reg;
                otgt0_reg  <= otgt1_reg;
                ocnt_reg   <= ocnt_reg - 2'd1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        val_reg   <= s_tdata[31:0];
                        now_reg   <= s_tdata[63:32];
                        run_reg   <= s_tdata[64];
                        pos_reg   <= s_tdata[96:65];
                        togo_reg  <= s_tdata[128:97];
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    rcmd0_reg  <= CMD_NONE;
                    rrate0_reg <= '0;
                    rtgt0_reg  <= '0;
                    rcmd1_reg  <= CMD_NONE;
                    rrate1_reg <= '0;
                    rtgt1_reg  <= '0;
                    rn_reg     <= 2'd1;
                    state_reg  <= ST_EMIT;
                    case (op_reg)
                        OP_TICK: begin
                            if (ramp_on_reg && !run_reg) begin
                                rev_pend_reg <= 1'b0;
                                if (rev_pend_reg && (rev_tgt_reg != pos_reg)) begin
                                    // The generator has stopped short of a reversal; start the new leg.
                                    ramp_rate_reg <= {1'b0, fl_q8};
                                    last_time_reg <= now_reg;
                                    rcmd0_reg     <= CMD_SET_RATE;
                                    rrate0_reg    <= fl_rate;
                                    rcmd1_reg     <= CMD_START;
                                    rtgt1_reg     <= rev_tgt_reg;
                                    rn_reg        <= 2'd2;
                                end else begin
                                    ramp_on_reg <= 1'b0;
                                    rcmd0_reg   <= CMD_SET_RATE;
                                    rrate0_reg  <= cruise_reg;
                                end
                            end else if (ramp_on_reg && (el >= TICK_US)) begin
                                move_mode_reg <= 1'b0;
                                pc_reg        <= PC_ACC_EL;
                                state_reg     <= ST_LOAD;
                            end
                        end
                        OP_MOVE_TO, OP_MOVE_BY: begin
                            if (drive_reg) begin
                                rev_pend_reg <= 1'b0;
                                tgt_reg      <= move_tgt;
                                if (run_reg && (togo_reg != 32'sd0)) begin
                                    move_mode_reg <= 1'b1;
                                    pc_reg        <= PC_VV;
                                    state_reg     <= ST_LOAD;
                                end else if (move_tgt == pos_reg) begin
                                    ramp_on_reg <= 1'b0;
                                end else begin
                                    ramp_on_reg   <= 1'b1;
                                    ramp_rate_reg <= {1'b0, fl_q8};
                                    last_time_reg <= now_reg;
                                    rcmd0_reg     <= CMD_SET_RATE;
                                    rrate0_reg    <= fl_rate;
                                    rcmd1_reg     <= CMD_START;
                                    rtgt1_reg     <= move_tgt;
                                    rn_reg        <= 2'd2;
                                end
                            end
                        end
                        OP_STOP: begin
                            rev_pend_reg <= 1'b0;
                            ramp_on_reg  <= 1'b0;
                            rcmd0_reg    <= CMD_STOP;
                            rcmd1_reg    <= CMD_SET_RATE;
                            rrate1_reg   <= cruise_reg;
                            rn_reg       <= 2'd2;
                        end
                        OP_SET_POS: begin
                            rev_pend_reg <= 1'b0;
                            ramp_on_reg  <= 1'b0;
                            rcmd0_reg    <= CMD_STOP;
                            rcmd1_reg    <= CMD_SET_POS;
                            rtgt1_reg    <= val_reg;
                            rn_reg       <= 2'd2;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_LOAD: begin
                    cnt_reg <= '0;
                    unique case (pc_reg)
                        PC_ACC_EL: begin
                            mcand_reg  <= {38'b0, accel_reg};
                            mplier_reg <= el;
                            prod_reg   <= '0;
                            state_reg  <= ST_MUL;
                        end
                        PC_DV: begin
                            quo_reg   <= {prod_reg[51:0], 8'b0};
                            rem_reg   <= '0;
                            dvsr_reg  <= {17'b0, US_PER_S};
                            state_reg <= ST_DIV;
                        end
                        PC_V_EL: begin
                            mcand_reg  <= {32'b0, ramp_rate_reg};
                            mplier_reg <= el;
                            prod_reg   <= '0;
                            state_reg  <= ST_MUL;
                        end
                        PC_TRAVEL: begin
                            quo_reg   <= {2'b0, prod_reg};
                            rem_reg   <= '0;
                            dvsr_reg  <= {17'b0, US_PER_S};
                            state_reg <= ST_DIV;
                        end
                        PC_VV: begin
                            mcand_reg  <= {32'b0, v_sel};
                            mplier_reg <= {6'b0, v_sel};
                            prod_reg   <= '0;
                            state_reg  <= ST_MUL;
                        end
                        PC_FF: begin
                            vv_reg     <= prod_reg[51:0];
                            mcand_reg  <= {33'b0, fl_q8};
                            mplier_reg <= {7'b0, fl_q8};
                            prod_reg   <= '0;
                            state_reg  <= ST_MUL;
                        end
                        PC_STOPD: begin
                            num_neg_reg <= num_s[52];
                            quo_reg     <= {8'b0, num_mag};
                            rem_reg     <= '0;
                            // Moves want whole steps, ticks want Q.8 steps.
                            dvsr_reg    <= move_mode_reg ? {accel_reg, 17'b0}
                                                         : {8'b0, accel_reg, 9'b0};
                            state_reg   <= ST_DIV;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_MUL: begin
                    prod_reg   <= mul_sum;
                    mcand_reg  <= {mcand_reg[56:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[31:1]};
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(MUL_STEPS - 1)) begin
                        pc_reg    <= pc_reg + 3'd1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_DIV: begin
                    quo_reg <= {quo_reg[58:0], div_ge};
                    rem_reg <= div_ge ? div_diff[36:0] : div_r2[36:0];
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                        pc_reg <= pc_reg + 3'd1;
                        if (pc_reg == PC_STOPD) begin
                            state_reg <= move_mode_reg ? ST_MOVE_FIN : ST_TICK_FIN;
                        end else begin
                            state_reg <= ST_LOAD;
                        end
                        if (pc_reg == PC_DV) begin
                            dv_reg <= {quo_reg[39:0], div_ge};
                        end
                        if (pc_reg == PC_TRAVEL) begin
                            trav_reg <= {quo_reg[37:0], div_ge};
                        end
                    end
                end
                ST_TICK_FIN: begin
                    // The update time moves only now, so the elapsed time stays valid meanwhile.
                    last_time_reg <= now_reg;
                    ramp_rate_reg <= v_new;
                    if (v_new[25:8] != ramp_rate_reg[25:8]) begin
                        rcmd0_reg  <= CMD_SET_RATE;
                        rrate0_reg <= v_new[24:8];
                    end
                    state_reg <= ST_EMIT;
                end
                ST_MOVE_FIN: begin
                    ramp_on_reg <= 1'b1;
                    rcmd0_reg   <= CMD_RETARGET;
                    if (far) begin
                        rtgt0_reg <= tgt_reg;
                    end else begin
                        // Too close to stop before the target: stop at the nearest point first.
                        rtgt0_reg    <= stop_pt;
                        rev_tgt_reg  <= tgt_reg;
                        rev_pend_reg <= 1'b1;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (ocnt_reg == 2'd0) begin
                        ocmd0_reg  <= rcmd0_reg;
                        orate0_reg <= rrate0_reg;
                        otgt0_reg  <= rtgt0_reg;
                        ocmd1_reg  <= rcmd1_reg;
                        orate1_reg <= rrate1_reg;
                        otgt1_reg  <= rtgt1_reg;
                        obusy_reg  <= run_reg || rev_pend_reg;
                        oend_reg   <= rev_pend_reg ? rev_tgt_reg : (pos_reg + togo_reg);
                        ocnt_reg   <= rn_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_we) begin
                case (cfg_index)
                    REG_CRUISE: cruise_reg <= cfg_cruise;
                    REG_ACCEL:  accel_reg  <= (cfg_wdata == 20'd0) ? 20'd1 : cfg_wdata;
                    REG_DRIVE: begin
                        drive_reg <= cfg_wdata[0];
                        if (!cfg_wdata[0]) begin
                            rev_pend_reg <= 1'b0;
                            ramp_on_reg  <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTH
    a_pend_needs_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        rev_pend_reg |-> ramp_on_reg)
        else $error("reversal pending without an active ramp");

    a_cfg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (accel_reg != 20'd0) && (cruise_reg != 17'd0) && (int'(cruise_reg) <= MAX_STEP_RATE))
        else $error("rate settings out of range");

    a_out_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg != 2'd3)
        else $error("result buffer count broken");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && ocnt_reg == 2'd0) |=> ocnt_reg != 2'd0)
        else $error("results not loaded into the output buffer");

    a_one_beat_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (ocnt_reg == 2'd0 || $past(state_reg) == ST_EMIT))
        else $error("results remain after the last beat");
`endif

endmodule

@@ tb/tb.sv @@
module tb;
    import tpm_pkg::*;

    typedef struct {
        cmd_t          cmd;
        bit [16:0]     rate;
        bit [31:0]     tgt;
        bit            busy;
        bit [31:0]     end_pos;
        bit            last;
    } gen_cmd_t;

    localparam longint unsigned MAX_RATE = 100000;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [19:0]  cfg_wdata;

    trapezoid_ramp_move_planner_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Planner copy: registers and ramp state.
    longint unsigned cruise_sps, accel_sps2, rate_q8;
    bit              drive_on, ramping, rev_pend;
    bit [31:0]       last_upd_us;
    longint          rev_tgt;

    gen_cmd_t  expected_cmds[$];
    gen_cmd_t  plan_out[$];
    int        errors = 0;

    // Pulse generator stand-in that follows the commands the planner emits.
    int        g_pos, g_togo;
    bit        g_run;
    bit [31:0] g_now;

    int burst_left = 0;
    int hold_cnt = 0;
    bit hold_req = 0;
    int rdy_mode = 0;
    int rdy_phase = 0;

    function automatic longint wrap32(longint x);
        return longint'(int'(x));
    endfunction

    function automatic longint unsigned floor_q8();
        return ((cruise_sps < RAMP_FLOOR) ? cruise_sps : longint'(RAMP_FLOOR)) << 8;
    endfunction

    function automatic void add_cmd(cmd_t c, longint unsigned r, longint t);
        gen_cmd_t e;
        if (plan_out.size() < 2) begin
            e.cmd = c;
            e.rate = r[16:0];
            e.tgt = t[31:0];
            plan_out.push_back(e);
        end
    endfunction

    function automatic longint stop_dist_steps();
        longint unsigned fl, v;
        longint num, d;
        fl = floor_q8();
        v = ramping ? rate_q8 : fl;
        num = longint'(v * v) - longint'(fl * fl);
        if (num <= 0)
            return 0;
        d = num / longint'(2 * accel_sps2 * 65536);
        return (d > 64'sd2147483647) ? 64'sd2147483647 : d;
    endfunction

    function automatic void start_ramp(longint target, bit [31:0] now);
        rate_q8 = floor_q8();
        last_upd_us = now;
        ramping = 1'b1;
        add_cmd(CMD_SET_RATE, rate_q8 >> 8, 0);
        add_cmd(CMD_START, 0, target);
    endfunction

    function automatic void ramp_update(bit [31:0] now, bit run, longint pos, longint togo);
        bit [31:0] el;
        longint unsigned fl, vt, v, dv, travel;
        longint sd, remain;
        if (!ramping)
            return;
        if (!run) begin
            if (rev_pend) begin
                rev_pend = 1'b0;
                if (rev_tgt != pos) begin
                    start_ramp(rev_tgt, now);
                    return;
                end
            end
            ramping = 1'b0;
            add_cmd(CMD_SET_RATE, cruise_sps, 0);
            return;
        end
        el = now - last_upd_us;
        if (el < TICK_US)
            return;
        last_upd_us = now;
        fl = floor_q8();
        vt = cruise_sps << 8;
        v = rate_q8;
        dv = accel_sps2 * longint'(el) * 256 / US_PER_S;
        travel = v * longint'(el) / US_PER_S;
        sd = (longint'(v * v) - longint'(fl * fl)) / longint'(2 * accel_sps2 * 256);
        remain = ((togo < 0) ? -togo : togo) * 256;
        if (remain <= sd + longint'(travel)) begin
            v = (v > dv) ? v - dv : 0;
            if (v < fl)
                v = fl;
        end else if (v < vt) begin
            v += dv;
            if (v > vt)
                v = vt;
        end else if (v > vt) begin
            v = vt;
        end
        if ((v >> 8) != (rate_q8 >> 8))
            add_cmd(CMD_SET_RATE, v >> 8, 0);
        rate_q8 = v;
    endfunction

    function automatic void plan_move(longint target, bit [31:0] now, bit run, longint pos,
                                      longint togo);
        longint dir, ahead, sd, steps;
        if (!drive_on)
            return;
        rev_pend = 1'b0;
        if (run && togo != 0) begin
            dir = (togo > 0) ? 1 : -1;
            ahead = (target - pos) * dir;
            sd = stop_dist_steps();
            ramping = 1'b1;
            if (ahead > sd) begin
                add_cmd(CMD_RETARGET, 0, target);
                return;
            end
            // Too close to turn around: stop at the nearest point, keep the target.
            steps = sd + 1;
            if (steps > togo * dir)
                steps = togo * dir;
            add_cmd(CMD_RETARGET, 0, wrap32(pos + dir * steps));
            rev_tgt = target;
            rev_pend = 1'b1;
            return;
        end
        if (target == pos) begin
            ramping = 1'b0;
            return;
        end
        start_ramp(target, now);
    endfunction

    function automatic void plan_item(bit [2:0] op, int val, bit [31:0] now, bit run,
                                      int pos_i, int togo_i);
        longint pos, togo, base, endp;
        bit busy;
        pos = pos_i;
        togo = togo_i;
        plan_out.delete();
        case (op)
            OP_TICK: ramp_update(now, run, pos, togo);
            OP_MOVE_TO: plan_move(longint'(val), now, run, pos, togo);
            OP_MOVE_BY: begin
                base = rev_pend ? rev_tgt : wrap32(pos + togo);
                plan_move(wrap32(base + val), now, run, pos, togo);
            end
            OP_STOP: begin
                rev_pend = 1'b0;
                ramping = 1'b0;
                add_cmd(CMD_STOP, 0, 0);
                add_cmd(CMD_SET_RATE, cruise_sps, 0);
            end
            OP_SET_POS: begin
                rev_pend = 1'b0;
                ramping = 1'b0;
                add_cmd(CMD_STOP, 0, 0);
                add_cmd(CMD_SET_POS, 0, longint'(val));
            end
            default: ;
        endcase
        if (plan_out.size() == 0)
            add_cmd(CMD_NONE, 0, 0);
        busy = run || rev_pend;
        endp = rev_pend ? rev_tgt : wrap32(pos + togo);
        foreach (plan_out[k]) begin
            plan_out[k].busy = busy;
            plan_out[k].end_pos = endp[31:0];
            plan_out[k].last = (k == plan_out.size() - 1);
            expected_cmds.push_back(plan_out[k]);
        end
    endfunction

    function automatic void apply_config(bit [1:0] idx, bit [19:0] wd);
        longint unsigned v;
        case (idx)
            REG_CRUISE: begin
                v = wd[16:0];
                if (v < 1) v = 1;
                if (v > MAX_RATE) v = MAX_RATE;
                cruise_sps = v;
            end
            REG_ACCEL: accel_sps2 = (wd == 0) ? 1 : wd;
            REG_DRIVE: begin
                drive_on = wd[0];
                if (!drive_on) begin
                    rev_pend = 1'b0;
                    ramping = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // Beats go out in bursts; each accepted beat is planned at the edge that takes it.
    task automatic send_item(bit [2:0] op, int val, bit [31:0] now, bit run, int pos, int togo);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, togo, pos, run, now, val};
        do @(posedge aclk); while (!s_tready);
        plan_item(op, val, now, run, pos, togo);
        // The beat is taken; drop valid so that it is not offered a second time.
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Feed the generator's commands back so that later snapshots stay consistent.
    task automatic follow_commands(int first);
        for (int k = first; k < expected_cmds.size(); k++) begin
            case (expected_cmds[k].cmd)
                CMD_START, CMD_RETARGET: g_togo = int'(expected_cmds[k].tgt) - g_pos;
                CMD_STOP: g_togo = 0;
                CMD_SET_POS: g_pos = int'(expected_cmds[k].tgt);
                default: ;
            endcase
        end
        g_run = (g_togo != 0);
    endtask

    task automatic send_snapshot(bit [2:0] op, int val);
        int first, k, mag;
        first = expected_cmds.size();
        send_item(op, val, g_now, g_run, g_pos, g_togo);
        follow_commands(first);
        if (g_togo != 0) begin
            mag = (g_togo < 0) ? -g_togo : g_togo;
            k = $urandom_range(0, (mag < 40) ? mag : 40);
            if (g_togo > 0) begin
                g_pos += k; g_togo -= k;
            end else begin
                g_pos -= k; g_togo += k;
            end
        end
        g_run = (g_togo != 0) || ($urandom_range(0, 19) == 0);
    endtask

    task automatic wait_idle();
        while (expected_cmds.size() != 0) @(posedge aclk);
        // Then leave the inputs quiet before the next step.
        repeat (400) @(negedge aclk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [19:0] wd);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wd;
        @(negedge aclk);
        cfg_we <= 1'b0;
        apply_config(idx, wd);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            g_now = $urandom;
            send_item($urandom_range(0, 7), $urandom, g_now, $urandom_range(0, 1), $urandom,
                      $urandom);
        end else begin
            g_now += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999)
                                                 : $urandom_range(1000, 3000);
            if (r < 70)
                send_snapshot(OP_TICK, 0);
            else if (r < 82)
                send_snapshot(OP_MOVE_TO, g_pos + $urandom_range(0, 6000) - 3000);
            else if (r < 93)
                send_snapshot(OP_MOVE_BY, $urandom_range(0, 6000) - 3000);
            else if (r < 97)
                send_snapshot(OP_STOP, 0);
            else
                send_snapshot(OP_SET_POS, $urandom_range(0, 2000) - 1000);
        end
    endtask

    task automatic test_directed();
        send_item(OP_TICK, 0, 32'd5000, 1'b0, 0, 0);
        send_item(OP_MOVE_TO, 0, 32'd6000, 1'b0, 0, 0);
        send_item(OP_MOVE_TO, 32'h7fffffff, 32'd7000, 1'b0, 32'h80000000, 0);
        send_item(OP_TICK, 0, 32'd7500, 1'b1, 32'h80000000, -1);
        send_item(OP_TICK, 0, 32'd9000, 1'b1, 100, 32'h7fffffff);
        send_item(OP_TICK, 0, 32'd10500, 1'b1, 200, 3);
        send_item(OP_MOVE_TO, 32'h80000000, 32'd11000, 1'b1, 200, 5);
        send_item(OP_MOVE_TO, 500, 32'd11500, 1'b1, 200, 100);
        send_item(OP_MOVE_BY, 32'h7fffffff, 32'd12000, 1'b1, 200, 0);
        send_item(OP_TICK, 0, 32'd13000, 1'b0, 210, 0);
        send_item(OP_TICK, 0, 32'hffffffff, 1'b0, 210, 0);
        send_item(OP_MOVE_BY, 32'h80000000, 32'd100, 1'b0, 32'h7fffffff, 32'h7fffffff);
        send_item(OP_MOVE_TO, -3, 32'd2000, 1'b1, 7, 32'h80000000);
        send_item(OP_TICK, 0, 32'd4000, 1'b1, 7, -2);
        send_item(OP_STOP, 0, 32'd4100, 1'b1, 5, 1);
        send_item(OP_SET_POS, 32'h80000000, 32'd4200, 1'b0, 5, 0);
        send_item(OP_SET_POS, 32'h7fffffff, 32'd4300, 1'b1, 5, 9);
        send_item(3'd5, 1, 32'd4400, 1'b0, 0, 0);
        send_item(3'd6, -1, 32'd4500, 1'b1, -1, -1);
        send_item(3'd7, 0, 32'hffffffff, 1'b1, 32'h7fffffff, 32'h80000000);
    endtask

    task automatic test_drive_disabled();
        write_reg(REG_DRIVE, 20'd0);
        send_item(OP_MOVE_TO, 1000, 32'd100, 1'b0, 0, 0);
        send_item(OP_MOVE_BY, -1000, 32'd200, 1'b1, 0, 50);
        send_item(OP_TICK, 0, 32'd3000, 1'b1, 0, 50);
        wait_idle();
        write_reg(REG_DRIVE, 20'hfffff);
        wait_idle();
    endtask

    task automatic test_profiles(bit [19:0] cruise, bit [19:0] accel, int n);
        wait_idle();
        write_reg(REG_CRUISE, cruise);
        write_reg(REG_ACCEL, accel);
        g_pos = 0; g_togo = 0; g_run = 0;
        repeat (n) random_item();
    endtask

    task automatic test_hold_off();
        @(negedge aclk);
        hold_req = 1'b1;
        repeat (12) random_item();
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_cnt = 500;
            hold_req = 1'b0;
        end
        if (rdy_phase == 0) begin
            rdy_phase = $urandom_range(16, 128);
            rdy_mode = $urandom_range(0, 2);
        end
        rdy_phase--;
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            case (rdy_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        gen_cmd_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cmds.size() == 0) begin
                $error("unexpected result beat: command %0d", m_tuser);
                errors++;
            end else begin
                e = expected_cmds.pop_front();
                if (m_tuser != e.cmd) begin
                    $error("command: expected %0d, got %0d", e.cmd, m_tuser); errors++;
                end
                if (m_tdata[16:0] != e.rate) begin
                    $error("rate_value: expected %0d, got %0d", e.rate, m_tdata[16:0]);
                    errors++;
                end
                if (m_tdata[48:17] != e.tgt) begin
                    $error("target_value: expected %0d, got %0d", $signed(e.tgt),
                           $signed(m_tdata[48:17]));
                    errors++;
                end
                if (m_tdata[49] != e.busy) begin
                    $error("axis_busy: expected %0d, got %0d", e.busy, m_tdata[49]); errors++;
                end
                if (m_tdata[81:50] != e.end_pos) begin
                    $error("planned_end: expected %0d, got %0d", $signed(e.end_pos),
                           $signed(m_tdata[81:50]));
                    errors++;
                end
                if (m_tlast != e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast); errors++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cruise_sps = CRUISE_RESET;
        accel_sps2 = ACCEL_RESET;
        drive_on = 1'b1;
        ramping = 1'b0;
        rate_q8 = 0;
        last_upd_us = '0;
        rev_pend = 1'b0;
        rev_tgt = 0;
        g_pos = 0; g_togo = 0; g_run = 0; g_now = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        wait_idle();
        test_drive_disabled();
        test_profiles(20'd2000, 20'd4000, 300);
        test_hold_off();
        test_profiles(20'd100000, 20'd1000000, 250);
        test_profiles(20'd0, 20'd0, 150);
        test_profiles(20'd400, 20'd1, 150);
        test_profiles(20'h1ffff, 20'hfffff, 150);
        test_profiles(20'd250, 20'd30000, 150);
        wait_idle();
        write_reg(2'd3, 20'hfffff);
        test_profiles(20'd5000, 20'd20000, 150);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_idle();
        if (errors == 0 && expected_cmds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tpm_pkg.sv
rtl/trapezoid_ramp_move_planner_unit.sv
tb/tb.sv
